// ----- rtl/xy_limit_homing_sequencer_defines.svh -----
// Assertion macros used by the homing sequencer checker.
`ifndef XY_LIMIT_HOMING_SEQUENCER_DEFINES_SVH
`define XY_LIMIT_HOMING_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define XYLHS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xylhs: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge.
`define XYLHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xylhs: next-cycle property failed");

`endif

// ----- rtl/xylhs_pkg.sv -----
// Types and constants for the XY limit-switch homing sequencer.
package xylhs_pkg;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_SEEK_X = 3'd1,
      PH_PAUSE  = 3'd2,
      PH_SEEK_Y = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   // One axis: the primary switch wins over the secondary on a tie.
   typedef struct packed {
      logic primary;
      logic secondary;
   } axis_hit_type;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAUSE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEEK_X_DUTY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEEK_Y_LEFT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEEK_Y_RIGHT = 3'd4;

   localparam logic [15:0] DEBOUNCE_RESET     = 16'd3125;
   localparam logic [19:0] PAUSE_RESET        = 20'd15625;
   localparam logic [7:0]  SEEK_X_DUTY_RESET  = 8'd200;
   localparam logic [7:0]  SEEK_Y_LEFT_RESET  = 8'd155;
   localparam logic [7:0]  SEEK_Y_RIGHT_RESET = 8'd150;

   // Bit positions in the latched hit flags.
   localparam int unsigned BIT_TOP    = 0;
   localparam int unsigned BIT_RIGHT  = 1;
   localparam int unsigned BIT_LEFT   = 2;
   localparam int unsigned BIT_BOTTOM = 3;

endpackage

// ----- rtl/xy_limit_homing_sequencer.sv -----
// Top level of the XY limit-switch homing sequencer.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+----------------------------------
//   req_    | in        | req_valid/req_stall  | one tick: command, four switches
//   rsp_    | out       | rsp_valid/rsp_stall  | motor drive, phase, clear, hits
//   csr_    | in        | csr_valid/csr_ready  | register index and write data
//
// Each tick word is handled in a single pass of compares and short counters between
// the state registers and the result register.
// A new word is taken in every cycle, unless a result word waits and rsp_stall is high.
// The result appears in the cycle after its tick word is accepted.
// Reset is synchronous and active high; it restores the register defaults and
// returns the sequencer to idle with all latches and lockouts clear.
module xy_limit_homing_sequencer (
   input  logic                                 clock,
   input  logic                                 reset,
   // Tick words.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic                                 req_switch_top,
   input  logic                                 req_switch_right,
   input  logic                                 req_switch_left,
   input  logic                                 req_switch_bottom,
   // Result words.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_left_direction,
   output logic                                 rsp_right_direction,
   output logic [7:0]                           rsp_left_duty,
   output logic [7:0]                           rsp_right_duty,
   output xylhs_pkg::phase_type                 rsp_phase,
   output logic                                 rsp_encoder_clear,
   output logic [3:0]                           rsp_hit_flags,
   // Register writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [xylhs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [xylhs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import xylhs_pkg::*;

   // Configuration registers.
   logic [15:0] debounce_ff;
   logic [19:0] pause_ticks_ff;
   logic [7:0]  seek_x_duty_ff;
   logic [7:0]  seek_y_left_ff;
   logic [7:0]  seek_y_right_ff;

   // Sequencer state.
   logic [3:0]  prev_levels_ff;
   logic [3:0]  hits_ff;
   logic [3:0]  hits_in;
   phase_type   phase_ff;
   phase_type   phase_in;
   logic [19:0] pause_cnt_ff;
   logic [19:0] pause_cnt_in;
   logic [19:0] pause_inc;

   // Result register.
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        left_dir_ff;
   logic        left_dir_in;
   logic        right_dir_ff;
   logic        right_dir_in;
   logic [7:0]  left_duty_ff;
   logic [7:0]  left_duty_in;
   logic [7:0]  right_duty_ff;
   logic [7:0]  right_duty_in;
   phase_type   phase_out_ff;
   logic        clear_ff;
   logic        clear_in;
   logic [3:0]  hit_flags_ff;

   logic         accept_req;
   logic         start;
   logic [3:0]   levels;
   logic [3:0]   rise;
   axis_hit_type x_rise;
   axis_hit_type y_rise;
   axis_hit_type x_accept;
   axis_hit_type y_accept;

   // The result register frees itself whenever its word is taken, so a new
   // tick can enter in the same cycle that the previous result leaves.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign accept_req = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= DEBOUNCE_RESET;
         pause_ticks_ff  <= PAUSE_RESET;
         seek_x_duty_ff  <= SEEK_X_DUTY_RESET;
         seek_y_left_ff  <= SEEK_Y_LEFT_RESET;
         seek_y_right_ff <= SEEK_Y_RIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE:     debounce_ff     <= csr_wdata[15:0];
            CSR_PAUSE:        pause_ticks_ff  <= csr_wdata[19:0];
            CSR_SEEK_X_DUTY:  seek_x_duty_ff  <= csr_wdata[7:0];
            CSR_SEEK_Y_LEFT:  seek_y_left_ff  <= csr_wdata[7:0];
            CSR_SEEK_Y_RIGHT: seek_y_right_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // Switch levels packed in hit-flag order, and their rising edges.
   assign start  = req_command;
   assign levels = {req_switch_bottom, req_switch_left, req_switch_right, req_switch_top};
   assign rise   = levels & ~prev_levels_ff;

   // Left beats right on the X axis, bottom beats top on the Y axis.
   always_comb begin
      x_rise.primary   = rise[BIT_LEFT];
      x_rise.secondary = rise[BIT_RIGHT];
      y_rise.primary   = rise[BIT_BOTTOM];
      y_rise.secondary = rise[BIT_TOP];
   end

   xylhs_lockout u_x_lockout (
      .clock          (clock),
      .reset          (reset),
      .advance        (accept_req),
      .rise           (x_rise),
      .debounce_ticks (debounce_ff),
      .accept         (x_accept)
   );

   xylhs_lockout u_y_lockout (
      .clock          (clock),
      .reset          (reset),
      .advance        (accept_req),
      .rise           (y_rise),
      .debounce_ticks (debounce_ff),
      .accept         (y_accept)
   );

   // A start clears the latches first; edges of the same tick land after it.
   always_comb begin
      hits_in = start ? 4'b0000 : hits_ff;
      hits_in[BIT_TOP]    = hits_in[BIT_TOP]    || y_accept.secondary;
      hits_in[BIT_RIGHT]  = hits_in[BIT_RIGHT]  || x_accept.secondary;
      hits_in[BIT_LEFT]   = hits_in[BIT_LEFT]   || x_accept.primary;
      hits_in[BIT_BOTTOM] = hits_in[BIT_BOTTOM] || y_accept.primary;
   end

   assign pause_inc = (pause_cnt_ff != 20'hFFFFF) ? pause_cnt_ff + 20'd1 : pause_cnt_ff;

   // Next phase. A start tick enters the left seek and goes no further; the
   // bottom seek also ends on a bottom hit that was latched earlier.
   always_comb begin
      phase_in     = phase_ff;
      pause_cnt_in = pause_cnt_ff;
      clear_in     = 1'b0;
      if (start) begin
         phase_in     = PH_SEEK_X;
         pause_cnt_in = '0;
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_SEEK_X: begin
               if (hits_in[BIT_LEFT]) begin
                  pause_cnt_in = '0;
                  phase_in     = (pause_ticks_ff == '0) ? PH_SEEK_Y : PH_PAUSE;
               end
            end
            PH_PAUSE: begin
               pause_cnt_in = pause_inc;
               if (pause_inc >= pause_ticks_ff) begin
                  phase_in = PH_SEEK_Y;
               end
            end
            PH_SEEK_Y: begin
               if (hits_in[BIT_BOTTOM]) begin
                  phase_in = PH_DONE;
                  clear_in = 1'b1;
               end
            end
            PH_DONE: begin
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // Motor drive follows the phase after this tick's update.
   always_comb begin
      left_dir_in   = 1'b0;
      right_dir_in  = 1'b0;
      left_duty_in  = '0;
      right_duty_in = '0;
      unique case (phase_in)
         PH_SEEK_X: begin
            left_duty_in  = seek_x_duty_ff;
            right_duty_in = seek_x_duty_ff;
         end
         PH_SEEK_Y: begin
            right_dir_in  = 1'b1;
            left_duty_in  = seek_y_left_ff;
            right_duty_in = seek_y_right_ff;
         end
         PH_DONE: right_dir_in = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_levels_ff <= '0;
         hits_ff        <= '0;
         phase_ff       <= PH_IDLE;
         pause_cnt_ff   <= '0;
      end else if (accept_req) begin
         prev_levels_ff <= levels;
         hits_ff        <= hits_in;
         phase_ff       <= phase_in;
         pause_cnt_ff   <= pause_cnt_in;
      end
   end

   // Result word: held while stalled, dropped once taken.
   always_comb begin
      if (accept_req) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_req) begin
         left_dir_ff   <= left_dir_in;
         right_dir_ff  <= right_dir_in;
         left_duty_ff  <= left_duty_in;
         right_duty_ff <= right_duty_in;
         phase_out_ff  <= phase_in;
         clear_ff      <= clear_in;
         hit_flags_ff  <= hits_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_direction  = left_dir_ff;
   assign rsp_right_direction = right_dir_ff;
   assign rsp_left_duty       = left_duty_ff;
   assign rsp_right_duty      = right_duty_ff;
   assign rsp_phase           = phase_out_ff;
   assign rsp_encoder_clear   = clear_ff;
   assign rsp_hit_flags       = hit_flags_ff;

endmodule

// ----- rtl/xylhs_lockout.sv -----
// Edge arbitration and debounce lockout timer for one axis.
module xylhs_lockout (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  xylhs_pkg::axis_hit_type rise,
   input  logic [15:0]            debounce_ticks,
   output xylhs_pkg::axis_hit_type accept
);
   import xylhs_pkg::*;

   logic        lock_ff;
   logic        lock_in;
   logic [15:0] count_ff;
   logic [15:0] count_in;
   logic [15:0] count_inc;
   logic        set_now;

   always_comb begin
      accept.primary   = !lock_ff && rise.primary;
      accept.secondary = !lock_ff && !rise.primary && rise.secondary;
   end

   assign set_now   = accept.primary || accept.secondary;
   assign count_inc = (count_ff != 16'hFFFF) ? count_ff + 16'd1 : count_ff;

   // A zero debounce setting releases after one tick, the same as one.
   always_comb begin
      lock_in  = lock_ff;
      count_in = count_ff;
      if (set_now) begin
         lock_in  = 1'b1;
         count_in = '0;
      end else if (lock_ff) begin
         count_in = count_inc;
         lock_in  = !(count_inc >= debounce_ticks);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff  <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         lock_ff  <= lock_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- rtl/xylhs_checker.sv -----
// Port-level checker for the homing sequencer and its bind.
`include "xy_limit_homing_sequencer_defines.svh"

module xylhs_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_left_direction,
   input  logic                                 rsp_right_direction,
   input  logic [7:0]                           rsp_left_duty,
   input  logic [7:0]                           rsp_right_duty,
   input  xylhs_pkg::phase_type                 rsp_phase,
   input  logic                                 rsp_encoder_clear,
   input  logic [3:0]                           rsp_hit_flags
);
   import xylhs_pkg::*;

   // A stalled result word stays put.
   `XYLHS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_phase) && $stable(rsp_hit_flags) && $stable(rsp_left_duty) && $stable(rsp_right_duty))

   // An accepted tick always yields a result word in the next cycle.
   `XYLHS_ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && !req_stall, rsp_valid)

   // The encoder clear only accompanies the done phase.
   `XYLHS_ASSERT_IMPLIES(a_clear_done, clock, reset, rsp_valid && rsp_encoder_clear, rsp_phase == PH_DONE)

   // Direction follows the phase: the right motor turns clockwise only going down.
   `XYLHS_ASSERT_IMPLIES(a_direction, clock, reset, rsp_valid, !rsp_left_direction && (rsp_right_direction == (rsp_phase == PH_SEEK_Y || rsp_phase == PH_DONE)))

   // No result is shown in the cycle after reset.
   `XYLHS_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind xy_limit_homing_sequencer xylhs_checker u_checker (.*);
